[rtl/gbs_pkg.sv]
// Shared types and constants of the gravity body step block.
// Used by the channel interfaces, the iterative unit and the top level.
package gbs_pkg;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_GRAVITY = 2'd1;
	localparam logic [1:0] OP_BOUNCE  = 2'd2;

	localparam logic [2:0] CFG_GAIN    = 3'd0;
	localparam logic [2:0] CFG_FLOOR   = 3'd1;
	localparam logic [2:0] CFG_CEILING = 3'd2;
	localparam logic [2:0] CFG_WIDTH   = 3'd3;
	localparam logic [2:0] CFG_HEIGHT  = 3'd4;
	localparam logic [2:0] CFG_RADIUS  = 3'd5;

	localparam int CNT_W      = 7;
	localparam int DIV_STEPS  = 64;
	localparam int SQRT_STEPS = 33;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] item_x;
		logic signed [31:0] item_y;
		logic signed [31:0] item_vx;
		logic signed [31:0] item_vy;
		logic [31:0]        other_mass;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x_out;
		logic signed [31:0] pos_y_out;
		logic signed [31:0] vel_x_out;
		logic signed [31:0] vel_y_out;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic is_sqrt;
	} iter_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] result;
	} iter_rsp_t;

endpackage

[rtl/gbs_ifs.sv]
// Valid/ready channel interfaces for input items and result items.
// Payload types come from gbs_pkg.
interface gbs_in_if;
	logic             valid;
	logic             ready;
	gbs_pkg::in_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface gbs_out_if;
	logic              valid;
	logic              ready;
	gbs_pkg::out_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[rtl/gbs_iter.sv]
// Shared shift-subtract unit: 64-bit by 32-bit division or 66-bit integer
// square root, one result bit per cycle. Depends on gbs_pkg.
module gbs_iter (
	input  logic               clk,
	input  logic               arst_n,
	input  gbs_pkg::iter_req_t req,
	input  logic [65:0]        num,
	input  logic [31:0]        den,
	output gbs_pkg::iter_rsp_t rsp
);

	logic                      busy_q;
	logic                      done_q;
	logic                      is_sqrt_q;
	logic [gbs_pkg::CNT_W-1:0] cnt_q;
	logic [65:0]               src_q;
	logic [35:0]               rem_q;
	logic [63:0]               res_q;
	logic [31:0]               den_q;

	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        ge;

	always_comb begin
		if (is_sqrt_q) begin
			rem_sh = {rem_q[33:0], src_q[65:64]};
			trial  = {res_q[33:0], 2'b01};
		end else begin
			rem_sh = {rem_q[34:0], src_q[65]};
			trial  = {4'b0, den_q};
		end
		ge = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			is_sqrt_q <= req.is_sqrt;
			src_q     <= req.is_sqrt ? num : {num[63:0], 2'b00};
			rem_q     <= '0;
			res_q     <= '0;
			den_q     <= den;
			cnt_q     <= req.is_sqrt ? gbs_pkg::CNT_W'(gbs_pkg::SQRT_STEPS - 1)
			                         : gbs_pkg::CNT_W'(gbs_pkg::DIV_STEPS - 1);
		end else if (busy_q) begin
			src_q <= is_sqrt_q ? {src_q[63:0], 2'b00} : {src_q[64:0], 1'b0};
			rem_q <= ge ? rem_sh - trial : rem_sh;
			res_q <= {res_q[62:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

[rtl/gravity_body_step_top.sv]
// Top level of the gravity body step block: body state, configuration,
// sequencer, shared multiplier. Depends on gbs_pkg, gbs_ifs and gbs_iter.
//
// channel   dir   handshake      payload
// item      in    valid/ready    operation, item_x, item_y, item_vx, item_vy, other_mass
// result    out   valid/ready    pos_x_out, pos_y_out, vel_x_out, vel_y_out
// cfg       in    cfg_we         cfg_index, cfg_data (no read-back)
//
// A gravity item with a nonzero offset uses two square roots and three divisions on the
// shared shift-subtract unit, up to 30 normalizing shift steps and ten passes through the
// shared multiplier; a zero offset skips the normalization, the second square root and
// the last two divisions.
// Reset clears the body state and resets the configuration; no clearing pass is needed.
// The next item is taken once the sequencer is idle, even while a result waits.
module gravity_body_step_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	gbs_in_if.sink      item,
	gbs_out_if.source   result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int RAD_SHIFT = 2 * FRAC_BITS;
	localparam int Q_SHIFT   = 24 - FRAC_BITS;
	localparam int NS        = 30;

	typedef enum logic [NS-1:0] {
		ST_IDLE   = NS'(1) << 0,
		ST_BOUNCE = NS'(1) << 1,
		ST_SQA    = NS'(1) << 2,
		ST_SQB    = NS'(1) << 3,
		ST_DSUM   = NS'(1) << 4,
		ST_DGO    = NS'(1) << 5,
		ST_DWAIT  = NS'(1) << 6,
		ST_DD     = NS'(1) << 7,
		ST_GM     = NS'(1) << 8,
		ST_GMST   = NS'(1) << 9,
		ST_QGO    = NS'(1) << 10,
		ST_QWAIT  = NS'(1) << 11,
		ST_NORM   = NS'(1) << 12,
		ST_NA2    = NS'(1) << 13,
		ST_NB2    = NS'(1) << 14,
		ST_RSUM   = NS'(1) << 15,
		ST_RGO    = NS'(1) << 16,
		ST_RWAIT  = NS'(1) << 17,
		ST_UXGO   = NS'(1) << 18,
		ST_UXWAIT = NS'(1) << 19,
		ST_UYGO   = NS'(1) << 20,
		ST_UYWAIT = NS'(1) << 21,
		ST_VX0    = NS'(1) << 22,
		ST_VX1    = NS'(1) << 23,
		ST_VX2    = NS'(1) << 24,
		ST_VY0    = NS'(1) << 25,
		ST_VY1    = NS'(1) << 26,
		ST_VY2    = NS'(1) << 27,
		ST_POS    = NS'(1) << 28,
		ST_DONE   = NS'(1) << 29
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic signed [31:0] gain_q;
	logic [15:0]        floor_q;
	logic [15:0]        ceil_q;
	logic [30:0]        width_q;
	logic [30:0]        height_q;
	logic [29:0]        radius_q;

	// Body state.
	logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;

	// Working registers of one gravity item.
	logic [32:0]  a_q, b_q, na_q, nb_q, mx_q;
	logic         dxneg_q, dyneg_q;
	logic [31:0]  mass_q;
	logic [65:0]  prod_q, sq_q, num_q;
	logic [31:0]  den_q;
	logic [15:0]  d_q;
	logic [63:0]  q_q;
	logic [30:0]  ux_q, uy_q;
	logic [63:0]  p0_q;

	logic               out_valid_q;
	gbs_pkg::out_item_t out_q;

	gbs_pkg::iter_req_t ireq;
	gbs_pkg::iter_rsp_t irsp;

	logic        accept;
	logic        out_free;
	logic [32:0] mul_a, mul_b;
	logic [32:0] dx, dy, abs_dx, abs_dy;
	logic [31:0] gain_mag;
	logic [32:0] rx, ry;
	logic [32:0] t_val;
	logic [15:0] d_clamp;
	logic [65:0] dist_sum;
	logic signed [31:0] bvx, bvy;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -35'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
		return sat32(-{{3{v[31]}}, v});
	endfunction

	// Adds the capped velocity step (q * unit) >> 30 to one velocity component.
	function automatic logic signed [31:0] vel_add(input logic signed [31:0] vel,
		input logic [63:0] p0, input logic [63:0] p1, input logic neg);
		logic [95:0] full;
		logic [65:0] vraw;
		logic [32:0] v;
		logic signed [34:0] stp;
		full = {p1, 32'b0} + {32'b0, p0};
		vraw = full[95:30];
		v    = (vraw > 66'h1_0000_0000) ? 33'h1_0000_0000 : vraw[32:0];
		stp  = neg ? -$signed({2'b00, v}) : $signed({2'b00, v});
		return sat32($signed({{3{vel[31]}}, vel}) + stp);
	endfunction

	assign accept     = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign out_free   = !out_valid_q || result.ready;

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	always_comb begin
		dx       = {pos_x_q[31], pos_x_q} - {item.payload.item_x[31], item.payload.item_x};
		dy       = {pos_y_q[31], pos_y_q} - {item.payload.item_y[31], item.payload.item_y};
		abs_dx   = dx[32] ? -dx : dx;
		abs_dy   = dy[32] ? -dy : dy;
		gain_mag = gain_q[31] ? -gain_q : gain_q;
		dist_sum = (sq_q + prod_q) >> RAD_SHIFT;
		t_val    = irsp.result[32:0];
		if (t_val < {17'b0, floor_q}) begin
			d_clamp = floor_q;
		end else if (t_val > {17'b0, ceil_q}) begin
			d_clamp = ceil_q;
		end else begin
			d_clamp = t_val[15:0];
		end
		if (d_clamp == '0) begin
			d_clamp = 16'd1;
		end
	end

	// Wall bounce: both tests of one axis may fire.
	always_comb begin
		rx  = {2'b00, width_q} - {2'b00, radius_q, 1'b0};
		ry  = {2'b00, height_q} - {2'b00, radius_q, 1'b0};
		bvx = vel_x_q;
		bvy = vel_y_q;
		if (pos_x_q <= 0) begin
			bvx = neg_sat(bvx);
		end
		if (pos_y_q <= 0) begin
			bvy = neg_sat(bvy);
		end
		if ($signed({pos_x_q[31], pos_x_q}) >= $signed(rx)) begin
			bvx = neg_sat(bvx);
		end
		if ($signed({pos_y_q[31], pos_y_q}) >= $signed(ry)) begin
			bvy = neg_sat(bvy);
		end
	end

	// Operand selection of the shared multiplier; the product is registered.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQA: begin
				mul_a = a_q;
				mul_b = a_q;
			end
			ST_SQB: begin
				mul_a = b_q;
				mul_b = b_q;
			end
			ST_DD: begin
				mul_a = {17'b0, d_q};
				mul_b = {17'b0, d_q};
			end
			ST_GM: begin
				mul_a = {1'b0, gain_mag};
				mul_b = {1'b0, mass_q};
			end
			ST_NA2: begin
				mul_a = na_q;
				mul_b = na_q;
			end
			ST_NB2: begin
				mul_a = nb_q;
				mul_b = nb_q;
			end
			ST_VX0: begin
				mul_a = {1'b0, q_q[31:0]};
				mul_b = {2'b0, ux_q};
			end
			ST_VX1: begin
				mul_a = {1'b0, q_q[63:32]};
				mul_b = {2'b0, ux_q};
			end
			ST_VY0: begin
				mul_a = {1'b0, q_q[31:0]};
				mul_b = {2'b0, uy_q};
			end
			ST_VY1: begin
				mul_a = {1'b0, q_q[63:32]};
				mul_b = {2'b0, uy_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign ireq.start   = (state_q == ST_DGO) || (state_q == ST_QGO) || (state_q == ST_RGO)
	                    || (state_q == ST_UXGO) || (state_q == ST_UYGO);
	assign ireq.is_sqrt = (state_q == ST_DGO) || (state_q == ST_RGO);

	gbs_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ireq),
		.num    (num_q),
		.den    (den_q),
		.rsp    (irsp)
	);

	// Sequencer, configuration and body state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			gain_q      <= '0;
			floor_q     <= 16'd1;
			ceil_q      <= 16'hFFFF;
			width_q     <= '0;
			height_q    <= '0;
			radius_q    <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gbs_pkg::CFG_GAIN:    gain_q   <= cfg_data;
					gbs_pkg::CFG_FLOOR:   floor_q  <= cfg_data[15:0];
					gbs_pkg::CFG_CEILING: ceil_q   <= cfg_data[15:0];
					gbs_pkg::CFG_WIDTH:   width_q  <= cfg_data[30:0];
					gbs_pkg::CFG_HEIGHT:  height_q <= cfg_data[30:0];
					gbs_pkg::CFG_RADIUS:  radius_q <= cfg_data[29:0];
					default: ;
				endcase
			end

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.payload.operation)
							gbs_pkg::OP_LOAD: begin
								pos_x_q <= item.payload.item_x;
								pos_y_q <= item.payload.item_y;
								vel_x_q <= item.payload.item_vx;
								vel_y_q <= item.payload.item_vy;
								state_q <= ST_DONE;
							end
							gbs_pkg::OP_GRAVITY: state_q <= ST_SQA;
							gbs_pkg::OP_BOUNCE:  state_q <= ST_BOUNCE;
							default:             state_q <= ST_DONE;
						endcase
					end
				end
				ST_BOUNCE: begin
					vel_x_q <= bvx;
					vel_y_q <= bvy;
					state_q <= ST_DONE;
				end
				ST_SQA:   state_q <= ST_SQB;
				ST_SQB:   state_q <= ST_DSUM;
				ST_DSUM:  state_q <= ST_DGO;
				ST_DGO:   state_q <= ST_DWAIT;
				ST_DWAIT: if (irsp.done) state_q <= ST_DD;
				ST_DD:    state_q <= ST_GM;
				ST_GM:    state_q <= ST_GMST;
				ST_GMST:  state_q <= ST_QGO;
				ST_QGO:   state_q <= ST_QWAIT;
				ST_QWAIT: if (irsp.done) state_q <= ST_NORM;
				ST_NORM: begin
					if (a_q == '0 && b_q == '0) begin
						state_q <= ST_VX0;
					end else if (mx_q[32:31] == 2'b00 && mx_q[30]) begin
						state_q <= ST_NA2;
					end
				end
				ST_NA2:    state_q <= ST_NB2;
				ST_NB2:    state_q <= ST_RSUM;
				ST_RSUM:   state_q <= ST_RGO;
				ST_RGO:    state_q <= ST_RWAIT;
				ST_RWAIT:  if (irsp.done) state_q <= ST_UXGO;
				ST_UXGO:   state_q <= ST_UXWAIT;
				ST_UXWAIT: if (irsp.done) state_q <= ST_UYGO;
				ST_UYGO:   state_q <= ST_UYWAIT;
				ST_UYWAIT: if (irsp.done) state_q <= ST_VX0;
				ST_VX0:    state_q <= ST_VX1;
				ST_VX1:    state_q <= ST_VX2;
				ST_VX2: begin
					vel_x_q <= vel_add(vel_x_q, p0_q, prod_q[63:0], gain_q[31] != dxneg_q);
					state_q <= ST_VY0;
				end
				ST_VY0: state_q <= ST_VY1;
				ST_VY1: state_q <= ST_VY2;
				ST_VY2: begin
					vel_y_q <= vel_add(vel_y_q, p0_q, prod_q[63:0], gain_q[31] != dyneg_q);
					state_q <= ST_POS;
				end
				ST_POS: begin
					pos_x_q <= sat32({{3{pos_x_q[31]}}, pos_x_q} + {{3{vel_x_q[31]}}, vel_x_q});
					pos_y_q <= sat32({{3{pos_y_q[31]}}, pos_y_q} + {{3{vel_y_q[31]}}, vel_y_q});
					state_q <= ST_DONE;
				end
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the gravity sequence.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			a_q     <= abs_dx;
			b_q     <= abs_dy;
			na_q    <= abs_dx;
			nb_q    <= abs_dy;
			mx_q    <= (abs_dx > abs_dy) ? abs_dx : abs_dy;
			dxneg_q <= dx[32];
			dyneg_q <= dy[32];
			mass_q  <= item.payload.other_mass;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q.pos_x_out <= pos_x_q;
			out_q.pos_y_out <= pos_y_q;
			out_q.vel_x_out <= vel_x_q;
			out_q.vel_y_out <= vel_y_q;
		end
		unique case (state_q)
			ST_SQB:  sq_q <= prod_q;
			ST_DSUM: num_q <= dist_sum;
			ST_DWAIT: if (irsp.done) d_q <= d_clamp;
			ST_GM:   den_q <= prod_q[31:0];
			ST_GMST: num_q <= prod_q;
			ST_QWAIT: if (irsp.done) q_q <= irsp.result >> Q_SHIFT;
			ST_NORM: begin
				if (a_q == '0 && b_q == '0) begin
					ux_q <= 31'h4000_0000;
					uy_q <= '0;
				end else if (mx_q[32:31] != 2'b00) begin
					na_q <= na_q >> 1;
					nb_q <= nb_q >> 1;
					mx_q <= mx_q >> 1;
				end else if (!mx_q[30]) begin
					na_q <= na_q << 1;
					nb_q <= nb_q << 1;
					mx_q <= mx_q << 1;
				end
			end
			ST_NB2:  sq_q <= prod_q;
			ST_RSUM: num_q <= sq_q + prod_q;
			ST_RWAIT: begin
				if (irsp.done) begin
					den_q <= irsp.result[31:0];
					num_q <= {5'b0, na_q[30:0], 30'b0};
				end
			end
			ST_UXWAIT: begin
				if (irsp.done) begin
					ux_q  <= irsp.result[30:0];
					num_q <= {5'b0, nb_q[30:0], 30'b0};
				end
			end
			ST_UYWAIT: if (irsp.done) uy_q <= irsp.result[30:0];
			ST_VX1:  p0_q <= prod_q[63:0];
			ST_VY1:  p0_q <= prod_q[63:0];
			default: ;
		endcase
	end

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ireq.start |-> !irsp.busy)
		else $error("iterative unit started while busy");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after an accepted item");

	a_dist_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DD) |-> (d_q != '0))
		else $error("force distance is zero");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NA2) |-> (mx_q[32:31] == 2'b00 && mx_q[30]))
		else $error("direction components not normalized");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VX0) |-> (ux_q <= 31'h4000_0000 && uy_q <= 31'h4000_0000))
		else $error("unit direction component above one");
`endif

endmodule
